// ----- src/csq_pkg.sv -----
`timescale 1ns / 1ps

package csq_pkg;

  // Default sizes of the block.
  localparam int QUEUE_DEPTH_DEF     = 16;
  localparam int COUNT_WIDTH_DEF     = 16;
  localparam int THREAD_ID_WIDTH_DEF = 8;

  // Fixed widths of the request, result and configuration fields.
  localparam int FUNC_W   = 2;
  localparam int TID_W    = 8;
  localparam int UNITS_W  = 16;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 16;

  // Operation codes of a request.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_WAIT   = 2'd0,
    FUNC_SIGNAL = 2'd1,
    FUNC_CLOSE  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  // Status codes of a result.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_GRANTED     = 3'd0,
    STATUS_BLOCKED     = 3'd1,
    STATUS_WOKEN       = 3'd2,
    STATUS_WOKEN_CLOSE = 3'd3,
    STATUS_REJECTED    = 3'd4,
    STATUS_FULL        = 3'd5,
    STATUS_SIGNAL_DONE = 3'd6,
    STATUS_CLOSE_DONE  = 3'd7
  } status_e;

  // One request.
  typedef struct packed {
    func_e              func;
    logic [TID_W-1:0]   thread_id;
    logic [UNITS_W-1:0] units;
  } req_t;

  // One result.
  typedef struct packed {
    logic [TID_W-1:0] thread_id_out;
    status_e          status;
    logic             last;
  } res_t;

endpackage

// ----- src/counting_semaphore_wait_queue_unit.sv -----
`timescale 1ns / 1ps

// Counting semaphore with an ordered queue of blocked multi-unit waiters. A
// request is taken when start is high and busy is low; each result appears on
// res_o for exactly one cycle with res_valid_o high, and the receiver cannot
// stall it, so it must take every result as it comes. A wait gives its single
// result in the cycle after it is taken and leaves the block ready again at
// once. A signal or a close walks the waiter queue, a memory with a registered
// read, issuing the read of each queued entry and then evaluating it; a close
// then makes a second pass over the waiters still queued (at most QUEUE_DEPTH).
// One result leaves per cycle at most. The initial count is written through
// the cfg channel while the block is idle; the write loads the count,
// saturated to its width, and leaves the queue alone.
module counting_semaphore_wait_queue_unit #(
  parameter int QUEUE_DEPTH     = csq_pkg::QUEUE_DEPTH_DEF,
  parameter int COUNT_WIDTH     = csq_pkg::COUNT_WIDTH_DEF,
  parameter int THREAD_ID_WIDTH = csq_pkg::THREAD_ID_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  csq_pkg::req_t             req_i,
  output logic                      res_valid_o,
  output csq_pkg::res_t             res_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [csq_pkg::CFG_W-1:0] cfg_data_i
);

  localparam int AW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW     = $clog2(QUEUE_DEPTH + 1);
  localparam int TW     = THREAD_ID_WIDTH;
  localparam int UW     = csq_pkg::UNITS_W;
  localparam int EW     = ((COUNT_WIDTH > UW) ? COUNT_WIDTH : UW) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WK_RD,
    ST_WK_EV,
    ST_CL_RD,
    ST_CL_EV
  } state_e;

  typedef struct packed {
    logic [TW-1:0] tid;
    logic [UW-1:0] units;
  } entry_t;

  state_e                 state_q;
  logic [COUNT_WIDTH-1:0] sem_q;
  logic                   closed_q;
  logic                   is_close_q;
  logic [FW-1:0]          fill_q;
  logic [FW-1:0]          rd_ptr_q;
  logic [FW-1:0]          wr_ptr_q;
  logic                   res_valid_q;
  csq_pkg::res_t          res_q;

  entry_t                 mem_q [QUEUE_DEPTH];
  entry_t                 rd_entry_q;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  entry_t                 mem_wdata;

  logic [TW-1:0]          req_tid;
  logic [EW-1:0]          sem_ext;
  logic [EW-1:0]          opd_ext;
  logic [EW-1:0]          sum_ext;
  logic [EW-1:0]          diff_ext;
  logic [EW-1:0]          max_ext;
  logic                   fits;
  logic [COUNT_WIDTH-1:0] sat_sum;
  logic                   req_take;
  logic                   queue_full;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE) && !start;
  assign req_take    = start && !busy;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign queue_full  = (fill_q == FW'(QUEUE_DEPTH));

  // The incoming thread id keeps only the stored width.
  assign req_tid = TW'(req_i.thread_id);

  // Shared count unit: compare, subtract, and saturating add against one operand.
  assign sem_ext  = EW'(sem_q);
  assign opd_ext  = (state_q == ST_WK_EV) ? EW'(rd_entry_q.units) : EW'(req_i.units);
  assign fits     = (sem_ext >= opd_ext);
  assign diff_ext = sem_ext - opd_ext;
  assign sum_ext  = sem_ext + opd_ext;
  assign max_ext  = {{(EW - COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};
  assign sat_sum  = (sum_ext > max_ext) ? {COUNT_WIDTH{1'b1}} : sum_ext[COUNT_WIDTH-1:0];

  // Queue write port: a new waiter at the tail, or a kept waiter moved down.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_q[AW-1:0];
    mem_wdata = '{tid: req_tid, units: req_i.units};
    if (state_q == ST_IDLE) begin
      mem_we = req_take && (req_i.func == csq_pkg::FUNC_WAIT) && !closed_q && !fits
               && !queue_full;
    end else if (state_q == ST_WK_EV) begin
      mem_we    = !fits;
      mem_waddr = wr_ptr_q[AW-1:0];
      mem_wdata = rd_entry_q;
    end
  end

  // Waiter queue storage with a registered read at the scan pointer.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_entry_q <= mem_q[rd_ptr_q[AW-1:0]];
  end

  // Sequencer: takes requests, runs the wake and close scans, drives results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sem_q       <= '0;
      closed_q    <= 1'b0;
      is_close_q  <= 1'b0;
      fill_q      <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (cfg_valid_i && cfg_ready_o) begin
            sem_q <= (EW'(cfg_data_i) > max_ext) ? {COUNT_WIDTH{1'b1}}
                                                 : COUNT_WIDTH'(cfg_data_i);
          end
          if (req_take) begin
            rd_ptr_q   <= '0;
            wr_ptr_q   <= '0;
            is_close_q <= (req_i.func == csq_pkg::FUNC_CLOSE);
            res_q.thread_id_out <= csq_pkg::TID_W'(req_tid);
            res_q.last          <= 1'b1;
            unique case (req_i.func)
              csq_pkg::FUNC_WAIT: begin
                res_valid_q <= 1'b1;
                if (closed_q) begin
                  res_q.status <= csq_pkg::STATUS_REJECTED;
                end else if (fits) begin
                  sem_q        <= diff_ext[COUNT_WIDTH-1:0];
                  res_q.status <= csq_pkg::STATUS_GRANTED;
                end else if (queue_full) begin
                  res_q.status <= csq_pkg::STATUS_FULL;
                end else begin
                  fill_q       <= fill_q + FW'(1);
                  res_q.status <= csq_pkg::STATUS_BLOCKED;
                end
              end
              csq_pkg::FUNC_SIGNAL: begin
                sem_q   <= sat_sum;
                state_q <= ST_WK_RD;
              end
              csq_pkg::FUNC_CLOSE: begin
                state_q <= ST_WK_RD;
              end
              default: begin
              end
            endcase
          end
        end

        // Issue the read of the next queued waiter, or finish the wake pass.
        ST_WK_RD: begin
          if (rd_ptr_q == fill_q) begin
            fill_q <= wr_ptr_q;
            if (is_close_q) begin
              rd_ptr_q <= '0;
              state_q  <= ST_CL_RD;
            end else begin
              res_valid_q         <= 1'b1;
              res_q.thread_id_out <= '0;
              res_q.status        <= csq_pkg::STATUS_SIGNAL_DONE;
              res_q.last          <= 1'b1;
              state_q             <= ST_IDLE;
            end
          end else begin
            state_q <= ST_WK_EV;
          end
        end

        // Wake the waiter if the count covers it, else keep it in order.
        ST_WK_EV: begin
          if (fits) begin
            sem_q               <= diff_ext[COUNT_WIDTH-1:0];
            res_valid_q         <= 1'b1;
            res_q.thread_id_out <= csq_pkg::TID_W'(rd_entry_q.tid);
            res_q.status        <= csq_pkg::STATUS_WOKEN;
            res_q.last          <= 1'b0;
          end else begin
            wr_ptr_q <= wr_ptr_q + FW'(1);
          end
          rd_ptr_q <= rd_ptr_q + FW'(1);
          state_q  <= ST_WK_RD;
        end

        // Read each remaining waiter for the close pass, or finish the close.
        ST_CL_RD: begin
          if (rd_ptr_q == fill_q) begin
            fill_q              <= '0;
            closed_q            <= 1'b1;
            res_valid_q         <= 1'b1;
            res_q.thread_id_out <= '0;
            res_q.status        <= csq_pkg::STATUS_CLOSE_DONE;
            res_q.last          <= 1'b1;
            state_q             <= ST_IDLE;
          end else begin
            state_q <= ST_CL_EV;
          end
        end

        // Report the waiter as woken by close.
        ST_CL_EV: begin
          res_valid_q         <= 1'b1;
          res_q.thread_id_out <= csq_pkg::TID_W'(rd_entry_q.tid);
          res_q.status        <= csq_pkg::STATUS_WOKEN_CLOSE;
          res_q.last          <= 1'b0;
          rd_ptr_q            <= rd_ptr_q + FW'(1);
          state_q             <= ST_CL_RD;
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sim/counting_semaphore_wait_queue_unit_tb.sv -----
`timescale 1ns / 1ps

module counting_semaphore_wait_queue_unit_tb;

  localparam int unsigned CLK_HALF      = 6;
  // Long enough for a close over a full queue to finish.
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int          COUNT_W       = csq_pkg::COUNT_WIDTH_DEF;
  localparam int          TID_W         = csq_pkg::TID_W;
  localparam int          UNITS_W       = csq_pkg::UNITS_W;
  localparam int          CFG_W         = csq_pkg::CFG_W;
  localparam int          QUEUE_DEPTH   = csq_pkg::QUEUE_DEPTH_DEF;
  localparam int unsigned COUNT_MAX     = (1 << COUNT_W) - 1;

  typedef enum logic {
    OP_REQUEST,
    OP_INIT_WRITE
  } op_kind_e;

  // One entry of the stimulus list: a request or a write of the initial count,
  // with the idle time that follows it.
  typedef struct {
    op_kind_e          kind;
    csq_pkg::req_t     req;
    logic [CFG_W-1:0]  init_val;
    int unsigned       gap;
  } pending_op_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  csq_pkg::req_t    req_i       = '0;
  logic             res_valid_o;
  csq_pkg::res_t    res_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  counting_semaphore_wait_queue_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  pending_op_t   pending_ops[$];
  csq_pkg::res_t expected_results[$];

  // Semaphore state as the block should hold it.
  logic [COUNT_W-1:0] sem_count  = '0;
  bit                 sem_closed = 1'b0;
  logic [TID_W-1:0]   waiter_tid[$];
  logic [UNITS_W-1:0] waiter_units[$];

  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned cycle_count  = 0;
  int unsigned gap_left     = 0;
  bit          gaps_enabled = 1'b1;
  logic        req_hit      = 1'b0;
  logic        cfg_hit      = 1'b0;

  csq_pkg::res_t    want_res;
  pending_op_t      op_now;
  logic             nxt_start;
  logic             nxt_cfg_valid;
  csq_pkg::req_t    nxt_req;
  logic [CFG_W-1:0] nxt_cfg_data;

  // Free-running clock.
  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // Run guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Append one expected result of the request being predicted.
  task automatic add_result(input logic [TID_W-1:0] tid, input csq_pkg::status_e st);
    csq_pkg::res_t r;
    r.thread_id_out = tid;
    r.status        = st;
    r.last          = 1'b0;
    expected_results.push_back(r);
  endtask

  // Wake the earliest queued waiter that the count covers, as long as one does.
  task automatic wake_fitting_waiters();
    int hit;
    hit = 0;
    while (hit >= 0) begin
      hit = -1;
      for (int i = 0; i < waiter_tid.size(); i++) begin
        if (hit < 0 && sem_count >= waiter_units[i]) hit = i;
      end
      if (hit >= 0) begin
        sem_count = sem_count - waiter_units[hit];
        add_result(waiter_tid[hit], csq_pkg::STATUS_WOKEN);
        waiter_tid.delete(hit);
        waiter_units.delete(hit);
      end
    end
  endtask

  // Update the semaphore for one taken request and queue the results it causes.
  task automatic semaphore_step(input csq_pkg::req_t r);
    int unsigned   first_new;
    int unsigned   sum;
    csq_pkg::res_t tail;
    first_new = expected_results.size();
    case (r.func)
      csq_pkg::FUNC_WAIT: begin
        if (sem_closed) begin
          add_result(r.thread_id, csq_pkg::STATUS_REJECTED);
        end else if (sem_count >= r.units) begin
          sem_count = sem_count - r.units;
          add_result(r.thread_id, csq_pkg::STATUS_GRANTED);
        end else if (waiter_tid.size() >= QUEUE_DEPTH) begin
          add_result(r.thread_id, csq_pkg::STATUS_FULL);
        end else begin
          waiter_tid.push_back(r.thread_id);
          waiter_units.push_back(r.units);
          add_result(r.thread_id, csq_pkg::STATUS_BLOCKED);
        end
      end
      csq_pkg::FUNC_SIGNAL: begin
        sum = 32'(sem_count) + 32'(r.units);
        sem_count = COUNT_W'((sum > COUNT_MAX) ? COUNT_MAX : sum);
        wake_fitting_waiters();
        add_result('0, csq_pkg::STATUS_SIGNAL_DONE);
      end
      csq_pkg::FUNC_CLOSE: begin
        wake_fitting_waiters();
        sem_closed = 1'b1;
        foreach (waiter_tid[i]) add_result(waiter_tid[i], csq_pkg::STATUS_WOKEN_CLOSE);
        waiter_tid.delete();
        waiter_units.delete();
        add_result('0, csq_pkg::STATUS_CLOSE_DONE);
      end
      default: begin
      end
    endcase
    // The final result of the request carries the last flag.
    if (expected_results.size() > first_new) begin
      tail = expected_results.pop_back();
      tail.last = 1'b1;
      expected_results.push_back(tail);
    end
  endtask

  // Check each result against the oldest expectation, then predict for a newly
  // taken request or register write.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) begin
        if (expected_results.size() == 0) begin
          $display("%0t: extra result: expected none, actual tid=%02h st=%0d last=%0b",
                   $time, res_o.thread_id_out, res_o.status, res_o.last);
          error_count++;
        end else begin
          want_res = expected_results.pop_front();
          if (res_o.thread_id_out !== want_res.thread_id_out ||
              res_o.status !== want_res.status || res_o.last !== want_res.last) begin
            $display("%0t: mismatch exp tid=%02h st=%0d last=%0b act tid=%02h st=%0d last=%0b",
                     $time, want_res.thread_id_out, want_res.status, want_res.last,
                     res_o.thread_id_out, res_o.status, res_o.last);
            error_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) sem_count = cfg_data_i;
      if (start && !busy) semaphore_step(req_i);
      quiet_cycles <= (res_valid_o || (start && !busy)) ? 0 : quiet_cycles + 1;
      req_hit      <= start && !busy;
      cfg_hit      <= cfg_valid_i && cfg_ready_o;
    end
  end

  // Drive requests and register writes from the stimulus list at the falling edge.
  // A register write waits until the block has gone quiet.
  always @(negedge clk_i) begin
    nxt_start     = start;
    nxt_cfg_valid = cfg_valid_i;
    nxt_req       = req_i;
    nxt_cfg_data  = cfg_data_i;
    if (rst_ni) begin
      if (start && req_hit) nxt_start = 1'b0;
      if (cfg_valid_i && cfg_hit) nxt_cfg_valid = 1'b0;
      if (!nxt_start && !nxt_cfg_valid && pending_ops.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops[0].kind == OP_REQUEST) begin
          op_now    = pending_ops.pop_front();
          nxt_start = 1'b1;
          nxt_req   = op_now.req;
          gap_left  = op_now.gap;
        end else if (expected_results.size() == 0 && quiet_cycles >= SETTLE_CYCLES &&
                     !busy) begin
          op_now        = pending_ops.pop_front();
          nxt_cfg_valid = 1'b1;
          nxt_cfg_data  = op_now.init_val;
          gap_left      = op_now.gap;
        end
      end
    end
    start       <= nxt_start;
    req_i       <= nxt_req;
    cfg_valid_i <= nxt_cfg_valid;
    cfg_data_i  <= nxt_cfg_data;
  end

  // Idle time after an item: mostly none, sometimes a few cycles, rarely long.
  function automatic int unsigned draw_gap();
    int unsigned pick;
    if (!gaps_enabled) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic queue_request(input csq_pkg::func_e f, input logic [TID_W-1:0] tid,
                               input logic [UNITS_W-1:0] amount);
    pending_op_t op;
    op.kind          = OP_REQUEST;
    op.req.func      = f;
    op.req.thread_id = tid;
    op.req.units     = amount;
    op.init_val      = '0;
    op.gap           = draw_gap();
    pending_ops.push_back(op);
  endtask

  task automatic queue_init_write(input logic [CFG_W-1:0] value);
    pending_op_t op;
    op.kind     = OP_INIT_WRITE;
    op.req      = '0;
    op.init_val = value;
    op.gap      = draw_gap();
    pending_ops.push_back(op);
  endtask

  // Mostly waits and signals with small unit counts, so that waiters queue up
  // and get woken; now and then full-range values and unused operations.
  task automatic queue_random_request(input bit allow_close);
    int unsigned        pick;
    logic [UNITS_W-1:0] amount;
    csq_pkg::func_e     f;
    pick = $urandom_range(0, 99);
    if (pick < 52) f = csq_pkg::FUNC_WAIT;
    else if (pick < 90) f = csq_pkg::FUNC_SIGNAL;
    else if (allow_close && pick < 95) f = csq_pkg::FUNC_CLOSE;
    else f = csq_pkg::FUNC_NONE;
    pick = $urandom_range(0, 99);
    if (f == csq_pkg::FUNC_SIGNAL) begin
      if (pick < 75) amount = UNITS_W'($urandom_range(0, 15));
      else if (pick < 88) amount = '1;
      else amount = UNITS_W'($urandom);
    end else begin
      if (pick < 70) amount = UNITS_W'($urandom_range(0, 12));
      else if (pick < 90) amount = UNITS_W'($urandom_range(0, 255));
      else amount = UNITS_W'($urandom);
    end
    queue_request(f, TID_W'($urandom_range(0, 255)), amount);
  endtask

  // Build the stimulus, release reset, and wait for the block to drain.
  initial begin
    // Directed part with the count left at its reset value of zero.
    queue_request(csq_pkg::FUNC_WAIT, 8'h00, 16'h0000);
    queue_request(csq_pkg::FUNC_WAIT, 8'hFF, 16'hFFFF);
    queue_request(csq_pkg::FUNC_WAIT, 8'hA5, 16'd5);
    queue_request(csq_pkg::FUNC_WAIT, 8'h5A, 16'd3);
    queue_request(csq_pkg::FUNC_SIGNAL, 8'h00, 16'd4);
    queue_request(csq_pkg::FUNC_SIGNAL, 8'h00, 16'd0);
    queue_request(csq_pkg::FUNC_NONE, 8'hFF, 16'hFFFF);
    // Saturating signal that wakes the largest waiter only.
    queue_request(csq_pkg::FUNC_SIGNAL, 8'h00, 16'hFFFF);
    queue_request(csq_pkg::FUNC_WAIT, 8'h3C, 16'd2);
    queue_request(csq_pkg::FUNC_SIGNAL, 8'h00, 16'd7);
    // A later waiter that fits is woken ahead of an earlier one that does not.
    queue_request(csq_pkg::FUNC_WAIT, 8'h11, 16'd9);
    queue_request(csq_pkg::FUNC_WAIT, 8'h22, 16'd1);
    queue_request(csq_pkg::FUNC_SIGNAL, 8'h00, 16'd1);

    // Random phases, each under its own initial count; one without idle time.
    for (int phase = 0; phase < 4; phase++) begin
      gaps_enabled = (phase != 2);
      case (phase)
        0: queue_init_write(16'hFFFF);
        1: queue_init_write(16'h0000);
        2: queue_init_write(CFG_W'($urandom));
        default: queue_init_write(CFG_W'($urandom_range(0, 40)));
      endcase
      for (int n = 0; n < 15; n++) queue_random_request(1'b0);
    end
    gaps_enabled = 1'b1;

    // Fill the queue until a wait is refused, then close over it.
    queue_init_write(16'h0000);
    for (int n = 0; n < QUEUE_DEPTH + 1; n++)
      queue_request(csq_pkg::FUNC_WAIT, TID_W'($urandom_range(0, 255)),
                    (n == 5) ? 16'd2 : 16'($urandom_range(4, 16'hFFFF)));
    queue_init_write(16'd3);
    queue_request(csq_pkg::FUNC_CLOSE, 8'h00, 16'd0);
    queue_request(csq_pkg::FUNC_WAIT, 8'hA0, 16'd1);
    queue_request(csq_pkg::FUNC_WAIT, 8'hFF, 16'd0);
    queue_request(csq_pkg::FUNC_SIGNAL, 8'h00, 16'd9);
    queue_request(csq_pkg::FUNC_CLOSE, 8'h00, 16'd0);
    queue_request(csq_pkg::FUNC_NONE, 8'h00, 16'd0);
    for (int n = 0; n < 8; n++) queue_random_request(1'b1);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() > 0 || start || cfg_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/csq_pkg.sv
src/counting_semaphore_wait_queue_unit.sv
sim/counting_semaphore_wait_queue_unit_tb.sv
